// ===== hw/rtl/slir_pkg.sv =====
package slir_pkg;

    localparam int DEF_CAPACITY = 64;

    localparam int OP_W   = 2;
    localparam int VAL_W  = 32;
    localparam int IDX_W  = 6;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_REMOVE = 2'd1;
    localparam t_op OP_UPDATE = 2'd2;
    localparam t_op OP_READ   = 2'd3;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;
    localparam t_status ST_BAD_INDEX = 2'd3;

    // datapath commands, one per cycle
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_RM_READ,
        CMD_RM_STEP,
        CMD_RM_END,
        CMD_INS_INIT,
        CMD_INS_NEW,
        CMD_INS_READ,
        CMD_INS_STEP,
        CMD_INS_PUT,
        CMD_IDX_READ,
        CMD_IDX_TAKE,
        CMD_FINISH
    } t_cmd;

    typedef struct packed {
        t_cmd    cmd;
        t_status status;
    } t_dp_ctl;

    typedef struct packed {
        logic full;
        logic rm_at_end;
        logic rm_none;
        logic ins_at_base;
        logic ins_hit;
        logic idx_ok;
    } t_dp_stat;

    typedef struct packed {
        t_status                  status;
        logic [CNT_W-1:0]         count;
        logic [CNT_W-1:0]         removed;
        logic signed [VAL_W-1:0]  read_value;
    } t_rsp;

endpackage

// ===== hw/rtl/slir_req_if.sv =====
interface slir_req_if;
    import slir_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] new_value;
    logic [IDX_W-1:0]        index;

    modport source (output valid, output op, output value, output new_value, output index,
                    input ready);
    modport sink   (input valid, input op, input value, input new_value, input index,
                    output ready);
endinterface

// ===== hw/rtl/slir_rsp_if.sv =====
interface slir_rsp_if;
    import slir_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic [CNT_W-1:0]        count;
    logic [CNT_W-1:0]        removed;
    logic signed [VAL_W-1:0] read_value;

    modport source (output valid, output status, output count, output removed,
                    output read_value, input ready);
    modport sink   (input valid, input status, input count, input removed,
                    input read_value, output ready);
endinterface

// ===== hw/rtl/sorted_list_insert_remove_update.sv =====
// Channel  Dir  Fields                                   Transfer
// i_req    in   op, value, new_value, index              valid & ready
// o_rsp    out  status, count, removed, read_value       valid & ready
//
// One item at a time; i_req is ready only while the sequencer is idle.
// Insert walks down from the top, shifting entries not below the value up, and skips the
// walk when full; remove scans the whole list; update runs a remove, then inserts the new
// value only when the old one was found; a read past the count returns ST_BAD_INDEX.
// A result waiting in o_rsp does not block the next request; only finishing
// the next item waits for it. Synchronous active-low reset empties the list.
module sorted_list_insert_remove_update #(
    parameter int CAPACITY = slir_pkg::DEF_CAPACITY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slir_req_if.sink   i_req,
    slir_rsp_if.source o_rsp
);
    import slir_pkg::*;

    t_dp_ctl  ctl;
    t_dp_stat stat;
    t_rsp     rsp;
    logic     rsp_valid;
    logic     req_ready;

    slir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_op    (i_req.op),
        .o_req_ready (req_ready),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_ctl       (ctl)
    );

    slir_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_req.value),
        .i_new_value (i_req.new_value),
        .i_index     (i_req.index),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .o_rsp       (rsp)
    );

    assign i_req.ready      = req_ready;
    assign o_rsp.valid      = rsp_valid;
    assign o_rsp.status     = rsp.status;
    assign o_rsp.count      = rsp.count;
    assign o_rsp.removed    = rsp.removed;
    assign o_rsp.read_value = rsp.read_value;

endmodule

// ===== hw/rtl/slir_datapath.sv =====
module slir_datapath #(
    parameter int CAPACITY = slir_pkg::DEF_CAPACITY
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic signed [slir_pkg::VAL_W-1:0] i_value,
    input  logic signed [slir_pkg::VAL_W-1:0] i_new_value,
    input  logic [slir_pkg::IDX_W-1:0]        i_index,
    input  slir_pkg::t_dp_ctl                 i_ctl,
    output slir_pkg::t_dp_stat                o_stat,
    output slir_pkg::t_rsp                    o_rsp
);
    import slir_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = (FW > IDX_W) ? FW : IDX_W;
    localparam logic [FW-1:0] FULL_CNT = FW'(CAPACITY);

    logic signed [VAL_W-1:0] mem [CAPACITY];

    logic [FW-1:0]           r_fill, n_fill;
    logic signed [VAL_W-1:0] r_key, n_key;
    logic signed [VAL_W-1:0] r_nval, n_nval;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [FW-1:0]           r_ptr, n_ptr;
    logic [FW-1:0]           r_wr, n_wr;
    logic [FW-1:0]           r_removed, n_removed;
    logic signed [VAL_W-1:0] r_rdval, n_rdval;
    logic signed [VAL_W-1:0] r_rdata;
    t_rsp                    r_rsp, n_rsp;

    logic                    we;
    logic [AW-1:0]           waddr;
    logic signed [VAL_W-1:0] wdata;
    logic                    re;
    logic [AW-1:0]           raddr;
    logic [FW-1:0]           ptr_dec;
    logic                    ins_hit;

    assign ptr_dec = r_ptr - 1'b1;
    assign ins_hit = r_rdata < r_key;

    assign o_stat.full        = (r_fill == FULL_CNT);
    assign o_stat.rm_at_end   = (r_ptr == r_fill);
    assign o_stat.rm_none     = (r_wr == r_fill);
    assign o_stat.ins_at_base = (r_ptr == '0);
    assign o_stat.ins_hit     = ins_hit;
    assign o_stat.idx_ok      = (CW'(r_idx) < CW'(r_fill));

    assign o_rsp = r_rsp;

    always_comb begin
        n_fill    = r_fill;
        n_key     = r_key;
        n_nval    = r_nval;
        n_idx     = r_idx;
        n_ptr     = r_ptr;
        n_wr      = r_wr;
        n_removed = r_removed;
        n_rdval   = r_rdval;
        n_rsp     = r_rsp;
        we        = 1'b0;
        waddr     = r_ptr[AW-1:0];
        wdata     = r_key;
        re        = 1'b0;
        raddr     = r_ptr[AW-1:0];
        unique case (i_ctl.cmd)
            CMD_LOAD: begin
                n_key     = i_value;
                n_nval    = i_new_value;
                n_idx     = i_index;
                n_ptr     = '0;
                n_wr      = '0;
                n_removed = '0;
                n_rdval   = '0;
            end
            CMD_RM_READ: begin
                re = 1'b1;
            end
            CMD_RM_STEP: begin
                // keep entries that differ from the key, packed down at r_wr
                n_ptr = r_ptr + 1'b1;
                if (r_rdata != r_key) begin
                    we    = 1'b1;
                    waddr = r_wr[AW-1:0];
                    wdata = r_rdata;
                    n_wr  = r_wr + 1'b1;
                end
            end
            CMD_RM_END: begin
                n_removed = r_fill - r_wr;
                n_fill    = r_wr;
            end
            CMD_INS_INIT: begin
                n_ptr = r_fill;
            end
            CMD_INS_NEW: begin
                n_ptr = r_fill;
                n_key = r_nval;
            end
            CMD_INS_READ: begin
                re    = 1'b1;
                raddr = ptr_dec[AW-1:0];
            end
            CMD_INS_STEP: begin
                // walk down from the top: shift up until an entry below the key
                we = 1'b1;
                if (ins_hit) begin
                    wdata  = r_key;
                    n_fill = r_fill + 1'b1;
                end else begin
                    wdata = r_rdata;
                    n_ptr = ptr_dec;
                end
            end
            CMD_INS_PUT: begin
                we     = 1'b1;
                n_fill = r_fill + 1'b1;
            end
            CMD_IDX_READ: begin
                re    = 1'b1;
                raddr = AW'(r_idx);
            end
            CMD_IDX_TAKE: begin
                n_rdval = r_rdata;
            end
            CMD_FINISH: begin
                n_rsp.status     = i_ctl.status;
                n_rsp.count      = CNT_W'(r_fill);
                n_rsp.removed    = CNT_W'(r_removed);
                n_rsp.read_value = r_rdval;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_nval    <= n_nval;
        r_idx     <= n_idx;
        r_ptr     <= n_ptr;
        r_wr      <= n_wr;
        r_removed <= n_removed;
        r_rdval   <= n_rdval;
        r_rsp     <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/slir_ctrl.sv =====
module slir_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_valid,
    input  slir_pkg::t_op            i_req_op,
    output logic                     o_req_ready,
    output logic                     o_rsp_valid,
    input  logic                     i_rsp_ready,
    input  slir_pkg::t_dp_stat       i_stat,
    output slir_pkg::t_dp_ctl        o_ctl
);
    import slir_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INS_GO   = 4'd1;
    localparam logic [3:0] S_INS_RD   = 4'd2;
    localparam logic [3:0] S_INS_CHK  = 4'd3;
    localparam logic [3:0] S_RM_RD    = 4'd4;
    localparam logic [3:0] S_RM_CHK   = 4'd5;
    localparam logic [3:0] S_INS_NEW  = 4'd6;
    localparam logic [3:0] S_IDX_RD   = 4'd7;
    localparam logic [3:0] S_IDX_TAKE = 4'd8;
    localparam logic [3:0] S_FIN      = 4'd9;

    logic [3:0] r_state, n_state;
    t_op        r_op, n_op;
    t_status    r_status, n_status;
    logic       r_out_valid, n_out_valid;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        o_ctl.cmd    = CMD_NONE;
        o_ctl.status = r_status;
        if (r_out_valid && i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_ctl.cmd = CMD_LOAD;
                    n_op      = i_req_op;
                    n_status  = ST_OK;
                    unique case (i_req_op)
                        OP_INSERT:            n_state = S_INS_GO;
                        OP_REMOVE, OP_UPDATE: n_state = S_RM_RD;
                        default:              n_state = S_IDX_RD;
                    endcase
                end
            end
            S_INS_GO: begin
                if (i_stat.full) begin
                    n_status = ST_FULL;
                    n_state  = S_FIN;
                end else begin
                    o_ctl.cmd = CMD_INS_INIT;
                    n_state   = S_INS_RD;
                end
            end
            S_INS_RD: begin
                if (i_stat.ins_at_base) begin
                    o_ctl.cmd = CMD_INS_PUT;
                    n_state   = S_FIN;
                end else begin
                    o_ctl.cmd = CMD_INS_READ;
                    n_state   = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                o_ctl.cmd = CMD_INS_STEP;
                n_state   = i_stat.ins_hit ? S_FIN : S_INS_RD;
            end
            S_RM_RD: begin
                if (i_stat.rm_at_end) begin
                    o_ctl.cmd = CMD_RM_END;
                    if (i_stat.rm_none) begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_FIN;
                    end else if (r_op == OP_UPDATE) begin
                        n_state = S_INS_NEW;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    o_ctl.cmd = CMD_RM_READ;
                    n_state   = S_RM_CHK;
                end
            end
            S_RM_CHK: begin
                o_ctl.cmd = CMD_RM_STEP;
                n_state   = S_RM_RD;
            end
            S_INS_NEW: begin
                o_ctl.cmd = CMD_INS_NEW;
                n_state   = S_INS_RD;
            end
            S_IDX_RD: begin
                if (i_stat.idx_ok) begin
                    o_ctl.cmd = CMD_IDX_READ;
                    n_state   = S_IDX_TAKE;
                end else begin
                    n_status = ST_BAD_INDEX;
                    n_state  = S_FIN;
                end
            end
            S_IDX_TAKE: begin
                o_ctl.cmd = CMD_IDX_TAKE;
                n_state   = S_FIN;
            end
            S_FIN: begin
                // output register free, or emptied by this cycle's transfer
                if (!r_out_valid || i_rsp_ready) begin
                    o_ctl.cmd   = CMD_FINISH;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
    end

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import slir_pkg::*;

    localparam int LIST_CAP     = DEF_CAPACITY;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_CYC   = 300;
    localparam int TARGET_ITEMS = 775;

    typedef logic signed [VAL_W-1:0] t_word;

    typedef enum logic [1:0] {
        RECV_FREE,
        RECV_RANDOM,
        RECV_ONE_IN_FOUR,
        RECV_BURSTY
    } t_recv_mode;

    localparam t_word W_MIN = 32'sh8000_0000;
    localparam t_word W_MAX = 32'sh7FFF_FFFF;

    logic i_clk;
    logic i_rst_n;

    slir_req_if req_if ();
    slir_rsp_if rsp_if ();

    sorted_list_insert_remove_update #(
        .CAPACITY (LIST_CAP)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow copy of the list, ascending
    t_word      shadow_list[$];
    t_rsp       pending_rsp_q[$];
    t_rsp       rsp_exp;
    int         err_cnt = 0;
    int         sent_cnt;
    int         burst_left;
    int         cycle_cnt = 0;
    int unsigned recv_cyc = 0;
    t_recv_mode recv_mode = RECV_FREE;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("sorted_list_insert_remove_update test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    function automatic void place_sorted(input t_word v);
        int pos;
        pos = 0;
        while (pos < shadow_list.size() && shadow_list[pos] < v)
            pos++;
        shadow_list.insert(pos, v);
    endfunction

    function automatic int drop_copies(input t_word v);
        t_word kept[$];
        int    n_gone;
        foreach (shadow_list[i])
            if (shadow_list[i] != v)
                kept.push_back(shadow_list[i]);
        n_gone = shadow_list.size() - kept.size();
        shadow_list = kept;
        return n_gone;
    endfunction

    function automatic t_rsp apply_to_shadow_list(input t_op op, input t_word value,
                                                  input t_word new_value,
                                                  input logic [IDX_W-1:0] index);
        t_rsp r;
        int   n_gone;
        r.status     = ST_OK;
        r.removed    = '0;
        r.read_value = '0;
        case (op)
            OP_INSERT: begin
                if (shadow_list.size() >= LIST_CAP)
                    r.status = ST_FULL;
                else
                    place_sorted(value);
            end
            OP_REMOVE: begin
                n_gone    = drop_copies(value);
                r.removed = CNT_W'(n_gone);
                if (n_gone == 0)
                    r.status = ST_NOT_FOUND;
            end
            OP_UPDATE: begin
                n_gone    = drop_copies(value);
                r.removed = CNT_W'(n_gone);
                if (n_gone == 0)
                    r.status = ST_NOT_FOUND;
                else
                    place_sorted(new_value);
            end
            OP_READ: begin
                if (int'(index) < shadow_list.size())
                    r.read_value = shadow_list[index];
                else
                    r.status = ST_BAD_INDEX;
            end
        endcase
        r.count = CNT_W'(shadow_list.size());
        return r;
    endfunction

    // ---------------------------------------------------------------
    // response side: stall pattern and checking
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            recv_cyc = recv_cyc + 1;
            if (recv_cyc % 64 == 0)
                recv_mode = t_recv_mode'($urandom_range(0, 3));
            case (recv_mode)
                RECV_FREE:        rsp_if.ready <= 1'b1;
                RECV_RANDOM:      rsp_if.ready <= 1'($urandom_range(0, 1));
                RECV_ONE_IN_FOUR: rsp_if.ready <= (recv_cyc % 4 == 0);
                RECV_BURSTY:      rsp_if.ready <= (recv_cyc % 8 < 3);
            endcase

            if (rsp_if.valid && rsp_if.ready) begin
                if (pending_rsp_q.size() == 0) begin
                    $error("response transfer with nothing expected");
                    err_cnt++;
                end else begin
                    rsp_exp = pending_rsp_q.pop_front();
                    if (rsp_if.status !== rsp_exp.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               rsp_exp.status, rsp_if.status);
                        err_cnt++;
                    end
                    if (rsp_if.count !== rsp_exp.count) begin
                        $error("count mismatch: expected %0d, actual %0d",
                               rsp_exp.count, rsp_if.count);
                        err_cnt++;
                    end
                    if (rsp_if.removed !== rsp_exp.removed) begin
                        $error("removed mismatch: expected %0d, actual %0d",
                               rsp_exp.removed, rsp_if.removed);
                        err_cnt++;
                    end
                    if (rsp_if.read_value !== rsp_exp.read_value) begin
                        $error("read_value mismatch: expected %0d, actual %0d",
                               rsp_exp.read_value, rsp_if.read_value);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------
    task automatic send_req(input t_op op, input t_word value, input t_word new_value,
                            input logic [IDX_W-1:0] index);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        req_if.valid     <= 1'b1;
        req_if.op        <= op;
        req_if.value     <= value;
        req_if.new_value <= new_value;
        req_if.index     <= index;
        do @(posedge i_clk); while (!req_if.ready);
        pending_rsp_q.push_back(apply_to_shadow_list(op, value, new_value, index));
        sent_cnt++;
    endtask

    // hold off until every response is back
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_rsp_q.size() != 0);
    endtask

    // mix of held values, small values with repeats, extremes and raw random
    function automatic t_word pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40 && shadow_list.size() > 0)
            return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
        if (r < 55)
            return t_word'(int'($urandom_range(0, 6)) - 3);
        if (r < 65) begin
            case ($urandom_range(0, 3))
                0:       return W_MIN;
                1:       return W_MAX;
                2:       return t_word'(0);
                default: return t_word'(-1);
            endcase
        end
        return t_word'($urandom());
    endfunction

    // weights in percent; reads take what is left
    task automatic random_item(input int w_ins, input int w_rm, input int w_upd);
        int                 r;
        t_op                op;
        t_word              v;
        t_word              nv;
        logic [IDX_W-1:0]   idx;
        r = $urandom_range(0, 99);
        if (r < w_ins)
            op = OP_INSERT;
        else if (r < w_ins + w_rm)
            op = OP_REMOVE;
        else if (r < w_ins + w_rm + w_upd)
            op = OP_UPDATE;
        else
            op = OP_READ;
        v  = pick_value();
        nv = ($urandom_range(0, 3) == 0) ? v : pick_value();
        if (shadow_list.size() > 0 && $urandom_range(0, 3) != 0)
            idx = IDX_W'($urandom_range(0, shadow_list.size() - 1));
        else
            idx = IDX_W'($urandom());
        send_req(op, v, nv, idx);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic test_empty_list();
        send_req(OP_READ,   t_word'(0), t_word'(0), 6'd0);
        send_req(OP_REMOVE, t_word'(7), t_word'(0), 6'd0);
        // absent old value: the new one must not appear
        send_req(OP_UPDATE, t_word'(7), t_word'(8), 6'd0);
        send_req(OP_READ,   t_word'(0), t_word'(0), 6'd63);
    endtask

    task automatic test_edge_values();
        send_req(OP_INSERT, W_MAX,       t_word'(0), 6'd0);
        send_req(OP_INSERT, W_MIN,       t_word'(0), 6'd0);
        send_req(OP_INSERT, t_word'(0),  t_word'(0), 6'd0);
        send_req(OP_INSERT, t_word'(-1), t_word'(0), 6'd0);
        repeat (3) send_req(OP_INSERT, t_word'(5), t_word'(0), 6'd0);
        send_req(OP_READ,   t_word'(0),  t_word'(0), 6'd0);
        send_req(OP_READ,   t_word'(0),  t_word'(0), 6'd6);
        send_req(OP_READ,   t_word'(0),  t_word'(0), 6'd7);
        // same old and new: all copies out, one back in
        send_req(OP_UPDATE, t_word'(5),  t_word'(5), 6'd0);
        send_req(OP_UPDATE, W_MAX,       W_MIN,      6'd0);
        send_req(OP_REMOVE, W_MIN,       t_word'(0), 6'd0);
        send_req(OP_UPDATE, t_word'(-1), t_word'(0), 6'd0);
        send_req(OP_READ,   t_word'(0),  t_word'(0), 6'd1);
        send_req(OP_REMOVE, t_word'(0),  t_word'(0), 6'd0);
        send_req(OP_READ,   t_word'(0),  t_word'(0), 6'd0);
        send_req(OP_REMOVE, t_word'(5),  t_word'(0), 6'd0);
        send_req(OP_READ,   t_word'(0),  t_word'(0), 6'd0);
    endtask

    task automatic test_random_mix(input int n);
        repeat (n) random_item(40, 15, 20);
    endtask

    task automatic test_fill_and_drain();
        int guard;
        guard = 0;
        while (shadow_list.size() < LIST_CAP && guard < 500) begin
            random_item(80, 5, 5);
            guard++;
        end
        // full list: inserts bounce, updates still fit
        repeat (12) random_item(50, 0, 25);
        guard = 0;
        while (shadow_list.size() > 0 && guard < 500) begin
            random_item(5, 70, 10);
            guard++;
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.op        <= OP_INSERT;
        req_if.value     <= '0;
        req_if.new_value <= '0;
        req_if.index     <= '0;
        sent_cnt   = 0;
        burst_left = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_edge_values();
        test_random_mix(120);
        wait_idle();
        test_fill_and_drain();
        test_fill_and_drain();
        test_random_mix((TARGET_ITEMS - sent_cnt > 50) ? TARGET_ITEMS - sent_cnt : 50);

        wait_idle();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (err_cnt == 0 && pending_rsp_q.size() == 0)
            $display("sorted_list_insert_remove_update test passed");
        else
            $display("sorted_list_insert_remove_update test failed");
        $finish;
    end

endmodule
